// ----- src/utf8d_pkg.sv -----
package utf8d_pkg;

  // Lead-byte classes, by the number of leading ones
  typedef enum logic [2:0] {
    CLS_ASCII = 3'd0,
    CLS_CONT  = 3'd1,
    CLS_LEAD2 = 3'd2,
    CLS_LEAD3 = 3'd3,
    CLS_BAD   = 3'd4
  } byte_cls_e;

  localparam logic [7:0] ASCII_MASK = 8'h7f;
  localparam logic [7:0] CONT_MASK  = 8'h3f;
  localparam logic [7:0] LEAD_MASK  = 8'h1f;
  localparam logic [7:0] TERM_BYTE  = 8'h00;

  // Decoder state shared with the top-level registers
  typedef struct packed {
    logic [1:0]  pending;
    logic [15:0] partial;
    logic        err;
  } dec_state_t;

  // Per-byte decision from the decode logic
  typedef struct packed {
    dec_state_t  nxt;
    logic        emit;
    logic        char_valid;
    logic        bad;
    logic        str_end;
    logic        cnt_inc;
    logic        cnt_clr;
    logic [15:0] code_point;
  } dec_ctl_t;

  // One result item as held in the output register
  typedef struct packed {
    logic [15:0] char_count;
    logic [15:0] code_point;
    logic        bad_encoding;
    logic        char_valid;
    logic        string_end;
  } res_t;

  function automatic byte_cls_e classify(input logic [7:0] b);
    byte_cls_e c;
    if (!b[7]) c = CLS_ASCII;
    else if (!b[6]) c = CLS_CONT;
    else if (!b[5]) c = CLS_LEAD2;
    else if (!b[4]) c = CLS_LEAD3;
    else c = CLS_BAD;
    return c;
  endfunction

endpackage

// ----- src/utf8d_decode.sv -----
module utf8d_decode
  import utf8d_pkg::*;
(
  input  logic [7:0] data_byte_i,
  input  dec_state_t state_i,
  output dec_ctl_t   ctl_o
);

  byte_cls_e cls;

  always_comb begin
    cls = classify(data_byte_i);
    ctl_o = '0;
    ctl_o.nxt = state_i;

    if (data_byte_i == TERM_BYTE) begin
      // terminator: unfinished sequence counts as an error
      ctl_o.emit    = 1'b1;
      ctl_o.str_end = 1'b1;
      ctl_o.bad     = state_i.err || (state_i.pending != 2'd0);
      ctl_o.cnt_clr = 1'b1;
      ctl_o.nxt     = '0;
    end else if (state_i.err) begin
      // drop until terminator
      ctl_o.emit = 1'b0;
    end else if (state_i.pending != 2'd0) begin
      if (cls != CLS_CONT) begin
        ctl_o.emit = 1'b1;
        ctl_o.bad  = 1'b1;
        ctl_o.nxt  = '{pending: 2'd0, partial: 16'd0, err: 1'b1};
      end else begin
        ctl_o.nxt.partial = {state_i.partial[9:0], data_byte_i[5:0] & CONT_MASK[5:0]};
        ctl_o.nxt.pending = state_i.pending - 2'd1;
        if (state_i.pending == 2'd1) begin
          ctl_o.emit       = 1'b1;
          ctl_o.char_valid = 1'b1;
          ctl_o.cnt_inc    = 1'b1;
          ctl_o.code_point = ctl_o.nxt.partial;
        end
      end
    end else begin
      unique case (cls)
        CLS_ASCII: begin
          ctl_o.emit       = 1'b1;
          ctl_o.char_valid = 1'b1;
          ctl_o.cnt_inc    = 1'b1;
          ctl_o.code_point = {8'd0, data_byte_i & ASCII_MASK};
        end
        CLS_LEAD2, CLS_LEAD3: begin
          ctl_o.nxt.partial = {8'd0, data_byte_i & LEAD_MASK};
          ctl_o.nxt.pending = (cls == CLS_LEAD2) ? 2'd1 : 2'd2;
        end
        default: begin
          ctl_o.emit = 1'b1;
          ctl_o.bad  = 1'b1;
          ctl_o.nxt  = '{pending: 2'd0, partial: 16'd0, err: 1'b1};
        end
      endcase
    end
  end

endmodule

// ----- src/utf8d_out_reg.sv -----
module utf8d_out_reg
  import utf8d_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  res_t res_i,
  output logic ready_o,
  output logic valid_o,
  input  logic take_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = wr_i ? 1'b1 : (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- src/utf8_to_ucs2_decoder.sv -----
// Path: byte register -> decode logic -> state and result registers; the
// result (if any) of an accepted byte is written to the result register.
// Throughput: one byte per cycle while the result side takes results.
// Backpressure on the result side stalls only bytes that produce a result.
// Reset (rst_ni low, asynchronous) empties both stages and clears the state.
module utf8_to_ucs2_decoder
  import utf8d_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] code_point, [31:16] char_count
  output logic [1:0]  m_axis_tuser_o,   // [0] char_valid, [1] bad_encoding
  output logic        m_axis_tlast_o    // string_end
);

  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  // input byte register
  logic       in_v_q, in_v_d;
  logic [7:0] in_byte_q;

  // decoder state
  dec_state_t             st_q;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic [31:0]            cnt_ext;

  dec_ctl_t ctl;
  res_t     res_d, res_q;
  logic     out_ready, out_valid, out_wr, adv;

  utf8d_decode u_decode (
    .data_byte_i (in_byte_q),
    .state_i     (st_q),
    .ctl_o       (ctl)
  );

  // A byte leaves the input register once its result (if any) has a slot.
  assign adv             = in_v_q && (!ctl.emit || out_ready);
  assign out_wr          = adv && ctl.emit;
  assign s_axis_tready_o = !in_v_q || adv;
  assign in_v_d          = s_axis_tvalid_i ? 1'b1 : (in_v_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // saturating character counter
  assign cnt_inc = (cnt_q == CntMax) ? cnt_q : cnt_q + COUNT_WIDTH'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (ctl.cnt_clr) cnt_d = '0;
    else if (ctl.cnt_inc) cnt_d = cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      cnt_q <= '0;
    end else if (adv) begin
      st_q  <= ctl.nxt;
      cnt_q <= cnt_d;
    end
  end

  // count reported with the result: after increment for chars, else current;
  // clipped to 16 bits for wide counters
  assign cnt_ext = 32'(ctl.cnt_inc ? cnt_inc : cnt_q);

  always_comb begin
    res_d.char_count   = (cnt_ext > 32'h0000_ffff) ? 16'hffff : cnt_ext[15:0];
    res_d.code_point   = ctl.code_point;
    res_d.bad_encoding = ctl.bad;
    res_d.char_valid   = ctl.char_valid;
    res_d.string_end   = ctl.str_end;
  end

  utf8d_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (out_wr),
    .res_i   (res_d),
    .ready_o (out_ready),
    .valid_o (out_valid),
    .take_i  (m_axis_tready_i),
    .res_o   (res_q)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {res_q.char_count, res_q.code_point};
  assign m_axis_tuser_o  = {res_q.bad_encoding, res_q.char_valid};
  assign m_axis_tlast_o  = res_q.string_end;

endmodule

// ----- src/utf8d_checker.sv -----
module utf8d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // end result never carries a character
  a_end_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> !m_axis_tuser_o[0] &&
      m_axis_tdata_o[15:0] == 16'd0)
    else $error("end result carries a character");

  // a character is never flagged bad and always counted
  a_char_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> !m_axis_tuser_o[1] &&
      !m_axis_tlast_o && m_axis_tdata_o[31:16] != 16'd0)
    else $error("bad character result");

  // reset empties the result stage
  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid in reset");

endmodule

bind utf8_to_ucs2_decoder utf8d_checker u_utf8d_checker (.*);

// ----- tb/sv/utf8_to_ucs2_decoder_test.sv -----
`timescale 1ns / 100ps

module utf8_to_ucs2_decoder_test;
  import utf8d_pkg::*;

  // One decoded result as seen on the output stream
  typedef struct packed {
    logic [15:0] code_point;
    logic        char_valid;
    logic        bad_encoding;
    logic        string_end;
    logic [15:0] char_count;
  } ucs2_result_t;

  localparam logic [15:0] COUNT_MAX = 16'hffff;
  localparam int          RANDOM_BYTES = 1850;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] data_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [15:0] code_point, [31:16] char_count
  logic [1:0]  m_axis_tuser_o;   // [0] char_valid, [1] bad_encoding
  logic        m_axis_tlast_o;   // string_end

  // Predictor state, tracks the decoder across strings
  logic [1:0]  dec_pending = '0;
  logic [15:0] dec_partial = '0;
  logic [15:0] dec_count   = '0;
  logic        dec_err     = 1'b0;

  ucs2_result_t ucs2_expected_q[$];
  int           live_bytes     = 0;  // bytes accepted so far
  int           mismatch_count = 0;
  int           src_max_gap    = 16;
  int           snk_max_stall  = 16;

  utf8_to_ucs2_decoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // Expected result for one accepted byte; pushes zero or one entry.
  function automatic void decode_byte(input logic [7:0] b);
    byte_cls_e    cls;
    ucs2_result_t r;
    logic         give;
    r    = '0;
    give = 1'b0;
    live_bytes++;
    casez (b)
      8'b0???????: cls = CLS_ASCII;
      8'b10??????: cls = CLS_CONT;
      8'b110?????: cls = CLS_LEAD2;
      8'b1110????: cls = CLS_LEAD3;
      default:     cls = CLS_BAD;
    endcase
    if (b == TERM_BYTE) begin
      // terminator: an open sequence counts as a missing continuation
      give           = 1'b1;
      r.string_end   = 1'b1;
      r.bad_encoding = dec_err || (dec_pending != 2'd0);
      r.char_count   = dec_count;
      dec_pending    = '0;
      dec_partial    = '0;
      dec_count      = '0;
      dec_err        = 1'b0;
    end else if (!dec_err) begin
      give = 1'b1;
      if (dec_pending != 2'd0) begin
        if (cls != CLS_CONT) begin
          r.bad_encoding = 1'b1;  // byte is consumed by the error
        end else begin
          dec_partial = (dec_partial << 6) | {8'h00, b & CONT_MASK};
          dec_pending = dec_pending - 2'd1;
          if (dec_pending == 2'd0) begin
            r.char_valid = 1'b1;
            r.code_point = dec_partial;
          end else begin
            give = 1'b0;
          end
        end
      end else begin
        case (cls)
          CLS_ASCII: begin
            r.char_valid = 1'b1;
            r.code_point = {8'h00, b & ASCII_MASK};
          end
          CLS_LEAD2, CLS_LEAD3: begin
            // lead keeps five bits; the 16-bit cut does the rest
            dec_partial = {8'h00, b & LEAD_MASK};
            dec_pending = (cls == CLS_LEAD2) ? 2'd1 : 2'd2;
            give        = 1'b0;
          end
          default: r.bad_encoding = 1'b1;  // stray cont or 4+ leading ones
        endcase
      end
      if (r.bad_encoding) begin
        dec_err     = 1'b1;
        dec_pending = '0;
        dec_partial = '0;
      end
      if (r.char_valid && dec_count != COUNT_MAX) dec_count++;
      r.char_count = dec_count;
    end
    if (give) ucs2_expected_q.push_back(r);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Result checker: compares each output handshake with the oldest expectation
  always @(posedge clk_i) begin : result_check
    ucs2_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (ucs2_expected_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%b tlast=%b",
                 $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      end else begin
        want = ucs2_expected_q.pop_front();
        check_field("code_point", want.code_point, m_axis_tdata_o[15:0]);
        check_field("char_count", want.char_count, m_axis_tdata_o[31:16]);
        check_field("char_valid", want.char_valid, m_axis_tuser_o[0]);
        check_field("bad_encoding", want.bad_encoding, m_axis_tuser_o[1]);
        check_field("string_end", want.string_end, m_axis_tlast_o);
      end
    end
  end

  // Result sink: ready is dropped for a random stall before each result
  initial begin : result_sink
    int stall;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, snk_max_stall);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Send one byte; valid stays high into the next request unless a gap is drawn
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    decode_byte(b);
  endtask

  // Hold off the source until every expected result has come out
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (ucs2_expected_q.size() != 0);
  endtask

  function automatic logic [7:0] rand_cont();
    return 8'($urandom_range(8'h80, 8'hbf));
  endfunction

  task automatic test_ascii();
    send_byte(8'h01);
    send_byte(8'h7f);
    send_byte(TERM_BYTE);
  endtask

  // Two-byte forms at U+0080 and U+07FF, three-byte forms at their payload extremes
  task automatic test_multibyte();
    send_byte(8'hc2); send_byte(8'h80);
    send_byte(8'hdf); send_byte(8'hbf);
    send_byte(8'he0); send_byte(8'h80); send_byte(8'h80);
    send_byte(8'hef); send_byte(8'hbf); send_byte(8'hbf);
    send_byte(TERM_BYTE);
  endtask

  task automatic test_stray_cont();
    send_byte(8'h80);
    send_byte(8'h41);  // dropped after the error
    send_byte(TERM_BYTE);
  endtask

  task automatic test_bad_lead();
    send_byte(8'hf0);
    send_byte(8'hff);  // dropped
    send_byte(TERM_BYTE);
  endtask

  // Non-continuation byte, then the terminator, inside an open sequence
  task automatic test_missing_cont();
    send_byte(8'hc3); send_byte(8'h41); send_byte(TERM_BYTE);
    send_byte(8'he2); send_byte(8'h82); send_byte(TERM_BYTE);
  endtask

  task automatic test_empty_string();
    send_byte(TERM_BYTE);
  endtask

  // Mostly well-formed strings, some with faults injected, some raw noise
  task automatic send_random_string();
    int         n, k, kind;
    bit         faulty;
    logic [7:0] lead;
    n = $urandom_range(0, 12);
    if ($urandom_range(0, 9) == 0) begin
      for (k = 0; k < n; k++) send_byte(8'($urandom_range(1, 255)));
    end else begin
      faulty = ($urandom_range(0, 3) == 0);
      for (k = 0; k < n; k++) begin
        kind = $urandom_range(0, faulty ? 9 : 7);
        case (kind)
          0, 1, 2, 3: send_byte(8'($urandom_range(1, 127)));
          4, 5: begin
            send_byte(8'($urandom_range(8'hc0, 8'hdf)));
            send_byte(rand_cont());
          end
          6, 7: begin
            send_byte(8'($urandom_range(8'he0, 8'hef)));
            send_byte(rand_cont());
            send_byte(rand_cont());
          end
          8: send_byte(rand_cont());
          default: begin
            if ($urandom_range(0, 1) == 0) begin
              send_byte(8'($urandom_range(8'hf0, 8'hff)));
            end else begin
              // truncated sequence, the next byte decides what follows
              lead = 8'($urandom_range(8'hc0, 8'hef));
              send_byte(lead);
              if (lead >= 8'he0 && $urandom_range(0, 1) == 0) send_byte(rand_cont());
            end
          end
        endcase
      end
    end
    send_byte(TERM_BYTE);
  endtask

  task automatic test_random();
    int start;
    bit drained;
    start   = live_bytes;
    drained = 1'b0;
    while (live_bytes - start < RANDOM_BYTES) begin
      if (!drained && live_bytes - start >= RANDOM_BYTES / 2) begin
        wait_drained();
        drained = 1'b1;
      end
      // stretches with no idling on one or both sides
      src_max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 16;
      snk_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 16;
      send_random_string();
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ascii();
    test_multibyte();
    test_stray_cont();
    test_bad_lead();
    test_missing_cont();
    test_empty_string();
    test_random();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && ucs2_expected_q.size() == 0) begin
      $display("[utf8_to_ucs2_decoder] OK");
    end else begin
      $display("[utf8_to_ucs2_decoder] ERROR");
    end
    $finish;
  end

  // Watchdog, well above the slowest legal run
  initial begin
    #6_000_000;
    $display("[utf8_to_ucs2_decoder] ERROR");
    $finish;
  end

endmodule
